// ----- src/mpeg_picture_start_scanner_assert.svh -----
// Assertion macros used by the scanner top level.
`ifndef MPEG_PICTURE_START_SCANNER_ASSERT_SVH
`define MPEG_PICTURE_START_SCANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("picture start scanner check failed");

// Next-cycle implication, checked outside reset.
`define MPSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("picture start scanner check failed");

`endif

// ----- src/mpsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpsc_pkg;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TIME  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ONE    = 3'd1;
    localparam logic [2:0] PH_TWO    = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_GOP0   = 3'd4;
    localparam logic [2:0] PH_GOP3   = 3'd7;

    localparam logic [7:0] ZERO_BYTE    = 8'h00;
    localparam logic [7:0] PREFIX_LAST  = 8'h01;
    localparam logic [7:0] PICTURE_CODE = 8'h00;
    localparam logic [7:0] GOP_CODE     = 8'hB8;

    typedef struct packed {
        logic               found;
        logic signed [63:0] pic_time;
        logic               pic_time_valid;
        logic [31:0]        time_code;
    } t_result;

endpackage

`default_nettype wire

// ----- src/mpsc_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpsc_core
    import mpsc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire logic [1:0]         i_op,
    input  wire logic [7:0]         i_byte_value,
    input  wire logic signed [63:0] i_time_value,
    input  wire logic               i_time_valid,
    output t_result                 o_result,
    output logic [2:0]              o_phase
);

    logic [2:0]         r_phase, n_phase;
    logic [3:1]         r_slot_valid, n_slot_valid;
    logic signed [63:0] r_slot_time [4];
    logic signed [63:0] n_slot_time [4];
    logic [3:0]         r_slot_known, n_slot_known;
    logic [7:0]         r_gop [4];
    logic [7:0]         n_gop [4];
    logic [31:0]        r_next_tc, n_next_tc;

    always_comb begin
        logic [1:0] idx;
        n_phase      = r_phase;
        n_slot_valid = r_slot_valid;
        n_slot_time  = r_slot_time;
        n_slot_known = r_slot_known;
        n_gop        = r_gop;
        n_next_tc    = r_next_tc;
        o_result     = '0;
        idx          = (r_phase >= PH_GOP0) ? 2'd0 : r_phase[1:0];
        if (i_take) begin
            case (i_op)
                OP_BYTE: begin
                    case (r_phase)
                        PH_IDLE: begin
                            if (i_byte_value == ZERO_BYTE) n_phase = PH_ONE;
                        end
                        PH_ONE: begin
                            if (i_byte_value == ZERO_BYTE) begin
                                n_phase = PH_TWO;
                            end else begin
                                n_phase = PH_IDLE;
                                if (r_slot_valid[1]) begin
                                    n_slot_time[0]  = r_slot_time[1];
                                    n_slot_known[0] = r_slot_known[1];
                                    n_slot_valid[1] = 1'b0;
                                end
                            end
                        end
                        PH_TWO: begin
                            if (i_byte_value == PREFIX_LAST) begin
                                n_phase = PH_PREFIX;
                            end else begin
                                if (r_slot_valid[1]) begin
                                    n_slot_time[0]  = r_slot_time[1];
                                    n_slot_known[0] = r_slot_known[1];
                                    n_slot_valid[1] = 1'b0;
                                end
                                if (i_byte_value == ZERO_BYTE) begin
                                    if (r_slot_valid[2]) begin
                                        n_slot_valid[1] = 1'b1;
                                        n_slot_time[1]  = r_slot_time[2];
                                        n_slot_known[1] = r_slot_known[2];
                                        n_slot_valid[2] = 1'b0;
                                    end
                                end else begin
                                    n_phase = PH_IDLE;
                                    if (r_slot_valid[2]) begin
                                        n_slot_time[0]  = r_slot_time[2];
                                        n_slot_known[0] = r_slot_known[2];
                                        n_slot_valid[2] = 1'b0;
                                    end
                                end
                            end
                        end
                        PH_PREFIX: begin
                            if (i_byte_value == PICTURE_CODE) begin
                                n_slot_time[0]          = '0;
                                n_slot_known[0]         = 1'b0;
                                o_result.found          = 1'b1;
                                o_result.pic_time_valid = r_slot_known[0];
                                o_result.pic_time       = r_slot_known[0] ? r_slot_time[0] : '0;
                                o_result.time_code      = r_next_tc;
                                n_next_tc               = r_next_tc + 32'd1;
                                n_phase                 = PH_IDLE;
                            end else if (i_byte_value == GOP_CODE) begin
                                n_phase = PH_GOP0;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                            for (int i = 1; i < 4; i++) begin
                                if (r_slot_valid[i]) begin
                                    n_slot_time[0]  = r_slot_time[i];
                                    n_slot_known[0] = r_slot_known[i];
                                    n_slot_valid[i] = 1'b0;
                                end
                            end
                        end
                        default: begin
                            n_gop[r_phase[1:0]] = i_byte_value;
                            if (r_phase == PH_GOP3) begin
                                n_phase   = PH_IDLE;
                                n_next_tc = {7'd0, r_gop[0], r_gop[1], r_gop[2],
                                             i_byte_value[7]};
                            end else begin
                                n_phase = r_phase + 3'd1;
                            end
                        end
                    endcase
                end
                OP_TIME: begin
                    n_slot_time[idx]  = i_time_valid ? i_time_value : '0;
                    n_slot_known[idx] = i_time_valid;
                    if (idx != 2'd0) n_slot_valid[idx] = 1'b1;
                end
                OP_CLEAR: begin
                    n_phase      = PH_IDLE;
                    n_next_tc    = '0;
                    n_slot_valid = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_slot_valid <= '0;
            r_next_tc    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_slot_valid <= n_slot_valid;
            r_next_tc    <= n_next_tc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_time  <= n_slot_time;
        r_slot_known <= n_slot_known;
        r_gop        <= n_gop;
    end

    assign o_phase = r_phase;

endmodule

`default_nettype wire

// ----- src/mpeg_picture_start_scanner.sv -----
// MPEG-1 picture start scanner.
// Input channel (i_valid / o_ready) carries one request per cycle: a stream
// byte, a sample timestamp, or a discontinuity reset, selected by i_op.
// Output channel (o_valid / i_ready) returns exactly one result per request,
// in order. A result is nonzero only when the byte completed a picture start
// code; it then carries the aligned picture time and the running time code.
// The result of a request is loaded into the output register at the edge
// that accepts it. All work is small logic on the scan state and four
// timestamp slots, so a request is accepted every cycle unless the
// receiver stalls. The single output register lets a new request enter
// in the cycle in which the held result is taken; while the receiver stalls,
// o_ready stays low and the result and the scan state hold.
// Synchronous reset clears the scan phase, the slot valid flags, the time
// code and the output valid flag; it needs no clearing pass and the block
// accepts requests in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "mpeg_picture_start_scanner_assert.svh"

module mpeg_picture_start_scanner
    import mpsc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_op,
    input  wire logic [7:0]         i_byte_value,
    input  wire logic signed [63:0] i_time_value,
    input  wire logic               i_time_valid,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_picture_found,
    output logic signed [63:0]      o_picture_time,
    output logic                    o_picture_time_valid,
    output logic [31:0]             o_time_code
);

    logic       r_out_valid;
    t_result    r_result;
    t_result    w_result;
    logic [2:0] w_phase;
    logic       w_take;

    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    mpsc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_op         (i_op),
        .i_byte_value (i_byte_value),
        .i_time_value (i_time_value),
        .i_time_valid (i_time_valid),
        .o_result     (w_result),
        .o_phase      (w_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) r_result <= w_result;
    end

    assign o_valid              = r_out_valid;
    assign o_picture_found      = r_result.found;
    assign o_picture_time       = r_result.pic_time;
    assign o_picture_time_valid = r_result.pic_time_valid;
    assign o_time_code          = r_result.time_code;

    `MPSC_ASSERT_IMP(a_empty_result, i_clk, i_rst_n, o_valid && !o_picture_found, o_picture_time == 64'sd0 && !o_picture_time_valid && o_time_code == 32'd0)
    `MPSC_ASSERT_IMP(a_unknown_time, i_clk, i_rst_n, o_valid && o_picture_found && !o_picture_time_valid, o_picture_time == 64'sd0)
    `MPSC_ASSERT_NXT(a_clear_phase, i_clk, i_rst_n, w_take && i_op == OP_CLEAR, w_phase == PH_IDLE)

endmodule

`default_nettype wire

// ----- dv/mpeg_picture_start_scanner_test.sv -----
`timescale 1ns / 1ps

module mpeg_picture_start_scanner_test;
    import mpsc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;
    localparam int STALL_CYCLES = 80;

    typedef enum logic [1:0] {
        MARK_NONE,
        MARK_PAUSE,
        MARK_STALL,
        MARK_BURST
    } t_mark;

    typedef struct {
        t_mark              mark;
        logic [1:0]         op;
        logic [7:0]         byte_v;
        logic signed [63:0] stamp;
        logic               stamp_ok;
    } t_feed_entry;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [1:0]         in_op = OP_BYTE;
    logic [7:0]         in_byte = 8'd0;
    logic signed [63:0] in_stamp = 64'sd0;
    logic               in_stamp_ok = 1'b0;
    logic               out_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic               o_picture_found;
    logic signed [63:0] o_picture_time;
    logic               o_picture_time_valid;
    logic [31:0]        o_time_code;

    t_feed_entry requests_pending [$];
    t_result     results_due [$];
    int          items_made = 0;
    int          err_count = 0;
    logic        req_fire = 1'b0;
    logic        sender_paused = 1'b0;
    logic        stream_idle = 1'b0;
    logic        burst = 1'b0;
    int          stall_req = 0;
    int          stall_taken = 0;
    int          stall_left = 0;

    // Scanner state as predicted from the accepted requests.
    logic [2:0]        phase = PH_IDLE;
    logic [3:0]        slot_live = '0;
    logic [3:0][63:0]  slot_stamp = '0;
    logic [3:0]        slot_known = '0;
    logic [3:0][7:0]   gop_bytes = '0;
    logic [31:0]       code_next = '0;

    mpeg_picture_start_scanner u_top (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (in_valid),
        .o_ready             (o_ready),
        .i_op                (in_op),
        .i_byte_value        (in_byte),
        .i_time_value        (in_stamp),
        .i_time_valid        (in_stamp_ok),
        .o_valid             (o_valid),
        .i_ready             (out_ready),
        .o_picture_found     (o_picture_found),
        .o_picture_time      (o_picture_time),
        .o_picture_time_valid(o_picture_time_valid),
        .o_time_code         (o_time_code)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic pull_slot(input int src);
        if (slot_live[src]) begin
            slot_stamp[0] = slot_stamp[src];
            slot_known[0] = slot_known[src];
            slot_live[src] = 1'b0;
        end
    endtask

    task automatic scan_request(input logic [1:0] op, input logic [7:0] b,
                                input logic signed [63:0] stamp, input logic stamp_ok,
                                output t_result res);
        logic [63:0] held_stamp;
        logic        held_known;
        int          idx;
        res = '0;
        case (op)
            OP_BYTE: begin
                case (phase)
                    PH_IDLE: begin
                        if (b == ZERO_BYTE) phase = PH_ONE;
                    end
                    PH_ONE: begin
                        if (b == ZERO_BYTE) begin
                            phase = PH_TWO;
                        end else begin
                            phase = PH_IDLE;
                            pull_slot(1);
                        end
                    end
                    PH_TWO: begin
                        if (b == PREFIX_LAST) begin
                            phase = PH_PREFIX;
                        end else if (b == ZERO_BYTE) begin
                            // A longer run of zeros shifts the parked times one slot down.
                            pull_slot(1);
                            if (slot_live[2]) begin
                                slot_live[1] = 1'b1;
                                slot_stamp[1] = slot_stamp[2];
                                slot_known[1] = slot_known[2];
                                slot_live[2] = 1'b0;
                            end
                        end else begin
                            phase = PH_IDLE;
                            pull_slot(1);
                            pull_slot(2);
                        end
                    end
                    PH_PREFIX: begin
                        held_stamp = slot_stamp[0];
                        held_known = slot_known[0];
                        if (b == PICTURE_CODE) begin
                            slot_stamp[0] = '0;
                            slot_known[0] = 1'b0;
                        end
                        for (int i = 1; i < 4; i++) pull_slot(i);
                        if (b == PICTURE_CODE) begin
                            phase = PH_IDLE;
                            res.found = 1'b1;
                            res.pic_time = held_known ? held_stamp : '0;
                            res.pic_time_valid = held_known;
                            res.time_code = code_next;
                            code_next = code_next + 32'd1;
                        end else begin
                            phase = (b == GOP_CODE) ? PH_GOP0 : PH_IDLE;
                        end
                    end
                    default: begin
                        gop_bytes[phase[1:0]] = b;
                        if (phase == PH_GOP3) begin
                            phase = PH_IDLE;
                            code_next = (32'(gop_bytes[0]) << 17) + (32'(gop_bytes[1]) << 9)
                                      + (32'(gop_bytes[2]) << 1) + 32'(gop_bytes[3][7]);
                        end else begin
                            phase = phase + 3'd1;
                        end
                    end
                endcase
            end
            OP_TIME: begin
                idx = (phase >= PH_GOP0) ? 0 : int'(phase);
                slot_live[idx] = 1'b1;
                slot_stamp[idx] = stamp_ok ? stamp : '0;
                slot_known[idx] = stamp_ok;
            end
            OP_CLEAR: begin
                phase = PH_IDLE;
                code_next = '0;
                slot_live = '0;
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [63:0] pick_time();
        case ($urandom_range(0, 9))
            0: return TIME_MIN;
            1: return TIME_MAX;
            2: return 64'($urandom_range(0, 1000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_req(input logic [1:0] op, input logic [7:0] b,
                            input logic signed [63:0] stamp, input logic stamp_ok);
        t_feed_entry e;
        e.mark = MARK_NONE;
        e.op = op;
        e.byte_v = b;
        e.stamp = stamp;
        e.stamp_ok = stamp_ok;
        requests_pending.push_back(e);
        if (op != OP_UNUSED) items_made++;
    endtask

    task automatic push_mark(input t_mark m);
        t_feed_entry e;
        e = '{m, OP_BYTE, 8'd0, 64'sd0, 1'b0};
        requests_pending.push_back(e);
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_req(OP_BYTE, b, pick_time(), 1'($urandom_range(0, 1)));
    endtask

    task automatic push_time(input logic signed [63:0] stamp, input logic stamp_ok);
        push_req(OP_TIME, 8'($urandom_range(0, 255)), stamp, stamp_ok);
    endtask

    task automatic maybe_time();
        if ($urandom_range(0, 2) == 0) push_time(pick_time(), $urandom_range(0, 3) != 0);
    endtask

    task automatic push_prefix(input int extra_zeros);
        push_byte(ZERO_BYTE);
        maybe_time();
        push_byte(ZERO_BYTE);
        maybe_time();
        repeat (extra_zeros) begin
            push_byte(ZERO_BYTE);
            maybe_time();
        end
        push_byte(PREFIX_LAST);
        maybe_time();
    endtask

    // Mostly well-formed start codes with random timing, plus broken prefixes, noise, clears and unused ops.
    task automatic push_random_sequence();
        int kind;
        kind = $urandom_range(0, 99);
        repeat ($urandom_range(0, 2)) begin
            maybe_time();
            push_byte(8'($urandom_range(0, 255)));
        end
        if (kind < 45) begin
            push_prefix($urandom_range(0, 2));
            push_byte(PICTURE_CODE);
        end else if (kind < 65) begin
            push_prefix($urandom_range(0, 1));
            push_byte(GOP_CODE);
            repeat (4) begin
                maybe_time();
                push_byte(8'($urandom_range(0, 255)));
            end
        end else if (kind < 75) begin
            push_prefix(0);
            push_byte(8'($urandom_range(0, 255)));
        end else if (kind < 94) begin
            push_byte(ZERO_BYTE);
            maybe_time();
            if ($urandom_range(0, 1) == 1) begin
                push_byte(ZERO_BYTE);
                maybe_time();
            end
            push_byte(8'($urandom_range(2, 255)));
        end else if (kind < 98) begin
            push_req(OP_CLEAR, 8'($urandom_range(0, 255)), pick_time(), 1'($urandom_range(0, 1)));
        end else begin
            push_req(OP_UNUSED, 8'($urandom_range(0, 255)), pick_time(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic push_random_run(input int count);
        int start;
        start = items_made;
        while (items_made - start < count) push_random_sequence();
    endtask

    always @(negedge clk) begin : driver
        t_feed_entry e;
        if (rst_n && (!in_valid || req_fire)) begin
            if (sender_paused) begin
                if (results_due.size() == 0) sender_paused = 1'b0;
                in_valid <= 1'b0;
            end else if (requests_pending.size() > 0 && requests_pending[0].mark != MARK_NONE) begin
                e = requests_pending.pop_front();
                case (e.mark)
                    MARK_PAUSE: sender_paused = 1'b1;
                    MARK_STALL: stall_req <= stall_req + 1;
                    default: burst <= !burst;
                endcase
                in_valid <= 1'b0;
            end else if (requests_pending.size() > 0 && (burst || $urandom_range(0, 99) >= 18)) begin
                e = requests_pending.pop_front();
                in_op <= e.op;
                in_byte <= e.byte_v;
                in_stamp <= e.stamp;
                in_stamp_ok <= e.stamp_ok;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_taken != stall_req) begin
            stall_taken <= stall_req;
            stall_left <= STALL_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= burst || $urandom_range(0, 99) >= 18;
        end
    end

    always @(posedge clk) begin : monitor
        t_result got;
        t_result want;
        req_fire = rst_n && in_valid && o_ready;
        if (rst_n) begin
            if (o_valid && out_ready) begin
                got.found = o_picture_found;
                got.pic_time = o_picture_time;
                got.pic_time_valid = o_picture_time_valid;
                got.time_code = o_time_code;
                if (results_due.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    err_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.found !== want.found) begin
                        $error("picture_found: expected %0d, got %0d", want.found, got.found);
                        err_count++;
                    end
                    if (got.pic_time !== want.pic_time) begin
                        $error("picture_time: expected %0d, got %0d",
                               $signed(want.pic_time), $signed(got.pic_time));
                        err_count++;
                    end
                    if (got.pic_time_valid !== want.pic_time_valid) begin
                        $error("picture_time_valid: expected %0d, got %0d",
                               want.pic_time_valid, got.pic_time_valid);
                        err_count++;
                    end
                    if (got.time_code !== want.time_code) begin
                        $error("time_code: expected %0d, got %0d", want.time_code, got.time_code);
                        err_count++;
                    end
                end
            end
            if (req_fire) begin
                scan_request(in_op, in_byte, in_stamp, in_stamp_ok, want);
                results_due.push_back(want);
            end
        end
        stream_idle = rst_n && (!in_valid || req_fire) && requests_pending.size() == 0
                    && results_due.size() == 0 && !sender_paused;
    end

    initial begin
        // The first request parks a time in slot 0, so every later picture reads a written slot.
        push_time(TIME_MAX, 1'b1);
        push_byte(ZERO_BYTE);
        push_time(TIME_MIN, 1'b1);
        push_byte(ZERO_BYTE);
        push_time(-64'sd1, 1'b0);
        push_byte(ZERO_BYTE);
        push_byte(PREFIX_LAST);
        push_time(64'sd777, 1'b1);
        push_byte(PICTURE_CODE);
        push_byte(ZERO_BYTE);
        push_byte(ZERO_BYTE);
        push_byte(PREFIX_LAST);
        push_byte(GOP_CODE);
        push_time(64'sd12345, 1'b1);
        repeat (4) push_byte(8'hFF);
        push_byte(ZERO_BYTE);
        push_byte(ZERO_BYTE);
        push_byte(PREFIX_LAST);
        push_byte(PICTURE_CODE);
        push_req(OP_CLEAR, 8'hA5, TIME_MAX, 1'b1);
        push_req(OP_UNUSED, 8'h5A, TIME_MIN, 1'b0);
        push_mark(MARK_PAUSE);
        push_random_run(450);
        push_mark(MARK_PAUSE);
        push_mark(MARK_BURST);
        push_random_run(300);
        push_mark(MARK_BURST);
        push_mark(MARK_STALL);
        push_random_run(250);
        push_mark(MARK_PAUSE);
        push_mark(MARK_STALL);
        push_random_run(400);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!stream_idle);
        repeat (5) @(posedge clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
